// File: design/csq_pkg.sv
// shared types and constants for the counting semaphore wait queue
`timescale 1ns / 1ps

package csq_pkg;

    // fixed field widths of the transaction payloads
    localparam int CSQ_OP_W      = 2;
    localparam int CSQ_TASK_W    = 8;
    localparam int CSQ_STATUS_W  = 4;
    localparam int CSQ_COUNT_W   = 16;
    localparam int CSQ_WAITERS_W = 5;
    localparam int CSQ_CFG_W     = 16;

    // request operations
    typedef enum logic [CSQ_OP_W-1:0] {
        OP_ACQUIRE     = 2'd0,
        OP_TRY_ACQUIRE = 2'd1,
        OP_RELEASE     = 2'd2,
        OP_CANCEL      = 2'd3
    } t_csq_op;

    // result status codes
    typedef enum logic [CSQ_STATUS_W-1:0] {
        ST_GRANTED    = 4'd0,
        ST_QUEUED     = 4'd1,
        ST_TRY_FAILED = 4'd2,
        ST_RAISED     = 4'd3,
        ST_WOKEN      = 4'd4,
        ST_CANCELLED  = 4'd5,
        ST_NOT_FOUND  = 4'd6,
        ST_QUEUE_FULL = 4'd7,
        ST_SATURATED  = 4'd8
    } t_csq_status;

    // request transaction
    typedef struct packed {
        logic [CSQ_OP_W-1:0]   op;
        logic [CSQ_TASK_W-1:0] task_id;
    } t_csq_in;

    // result transaction
    typedef struct packed {
        logic [CSQ_STATUS_W-1:0]  status;
        logic [CSQ_TASK_W-1:0]    woken_task;
        logic [CSQ_COUNT_W-1:0]   count_now;
        logic [CSQ_WAITERS_W-1:0] waiters_now;
    } t_csq_out;

    // controller to datapath commands
    typedef struct packed {
        logic        load;
        logic        cnt_dec;
        logic        cnt_inc;
        logic        enq;
        logic        deq;
        logic        drop;
        logic        idx_inc;
        logic        shift_wr;
        logic        rd_next;
        logic        emit;
        t_csq_status status;
    } t_csq_cmd;

    // datapath to controller status
    typedef struct packed {
        logic cnt_zero;
        logic cnt_max;
        logic q_empty;
        logic q_full;
        logic match;
        logic last;
    } t_csq_stat;

endpackage

// File: design/csq_ctrl.sv
// control state machine for the counting semaphore wait queue
`timescale 1ns / 1ps

module csq_ctrl
    import csq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [CSQ_OP_W-1:0] i_op,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  t_csq_stat           i_stat,
    output t_csq_cmd            o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state      r_state, n_state;
    t_csq_op     r_op, n_op;
    t_csq_status r_status, n_status;
    logic        r_out_valid, n_out_valid;
    logic        finish;
    logic        out_free;

    // output register can take a new transaction
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        finish      = 1'b0;
        o_cmd       = '0;
        o_cmd.rd_next = (r_state == S_SCAN) || (r_state == S_SHIFT);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = t_csq_op'(i_op);
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_ACQUIRE: begin
                        finish = 1'b1;
                        if (!i_stat.cnt_zero) begin
                            o_cmd.cnt_dec = 1'b1;
                            n_status      = ST_GRANTED;
                        end else if (!i_stat.q_full) begin
                            o_cmd.enq = 1'b1;
                            n_status  = ST_QUEUED;
                        end else begin
                            n_status = ST_QUEUE_FULL;
                        end
                    end
                    OP_TRY_ACQUIRE: begin
                        finish = 1'b1;
                        if (!i_stat.cnt_zero) begin
                            o_cmd.cnt_dec = 1'b1;
                            n_status      = ST_GRANTED;
                        end else begin
                            n_status = ST_TRY_FAILED;
                        end
                    end
                    OP_RELEASE: begin
                        finish = 1'b1;
                        if (!i_stat.q_empty) begin
                            o_cmd.deq = 1'b1;
                            n_status  = ST_WOKEN;
                        end else if (i_stat.cnt_max) begin
                            n_status = ST_SATURATED;
                        end else begin
                            o_cmd.cnt_inc = 1'b1;
                            n_status      = ST_RAISED;
                        end
                    end
                    OP_CANCEL: begin
                        if (i_stat.q_empty) begin
                            finish   = 1'b1;
                            n_status = ST_NOT_FOUND;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                // walk the queue oldest first, one entry per cycle
                if (i_stat.match) begin
                    if (i_stat.last) begin
                        o_cmd.drop = 1'b1;
                        finish     = 1'b1;
                        n_status   = ST_CANCELLED;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_SHIFT;
                    end
                end else if (i_stat.last) begin
                    finish   = 1'b1;
                    n_status = ST_NOT_FOUND;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_SHIFT: begin
                // close the gap, moving younger entries down by one
                o_cmd.shift_wr = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                if (i_stat.last) begin
                    o_cmd.drop = 1'b1;
                    finish     = 1'b1;
                    n_status   = ST_CANCELLED;
                end
            end
            S_DONE: begin
                finish = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hand the result to the output register
        if (finish) begin
            if (out_free) begin
                o_cmd.emit  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_state = S_DONE;
            end
        end

        o_cmd.status = n_status;
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_ACQUIRE;
            r_status    <= ST_GRANTED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: design/csq_dpath.sv
// count, waiter ring memory and result register of the semaphore
`timescale 1ns / 1ps

module csq_dpath
    import csq_pkg::*;
#(
    parameter int MAX_WAITERS  = 16,
    parameter int TASK_ID_BITS = 8,
    parameter int COUNT_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CSQ_CFG_W-1:0]  i_cfg_wr_data,
    input  logic [CSQ_TASK_W-1:0] i_task_id,
    input  t_csq_cmd              i_cmd,
    output t_csq_stat             o_stat,
    output t_csq_out              o_out
);

    localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CNT_W = $clog2(MAX_WAITERS + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [TASK_ID_BITS-1:0] r_waiter_ids [MAX_WAITERS];
    logic [TASK_ID_BITS-1:0] r_rd_data;
    logic [TASK_ID_BITS-1:0] r_task_id, n_task_id;
    logic [TASK_ID_BITS-1:0] r_woken, n_woken;
    logic [COUNT_BITS-1:0]   r_count, n_count;
    logic [CNT_W-1:0]        r_total, n_total;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [IDX_W-1:0]        r_head, n_head;
    t_csq_out                r_out;

    logic [CNT_W-1:0]                   idx_plus;
    logic [CNT_W-1:0]                   rd_off;
    logic [IDX_W-1:0]                   rd_addr;
    logic [IDX_W-1:0]                   wr_addr;
    logic [TASK_ID_BITS-1:0]            wr_data;
    logic                               wr_en;
    logic [COUNT_BITS+CSQ_CFG_W-1:0]    cfg_ext;
    logic [TASK_ID_BITS+CSQ_TASK_W-1:0] task_ext;
    logic [TASK_ID_BITS+CSQ_TASK_W-1:0] woken_ext;
    logic [COUNT_BITS+CSQ_COUNT_W-1:0]  count_ext;
    logic [CNT_W+CSQ_WAITERS_W-1:0]     total_ext;

    // ring position, sum stays below twice the depth
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = (s >= SUM_W'(MAX_WAITERS)) ? s - SUM_W'(MAX_WAITERS) : s;
        return t[IDX_W-1:0];
    endfunction

    // width adaptation of fields
    assign cfg_ext   = {{COUNT_BITS{1'b0}}, i_cfg_wr_data};
    assign task_ext  = {{TASK_ID_BITS{1'b0}}, i_task_id};
    assign woken_ext = {{CSQ_TASK_W{1'b0}}, n_woken};
    assign count_ext = {{CSQ_COUNT_W{1'b0}}, n_count};
    assign total_ext = {{CSQ_WAITERS_W{1'b0}}, n_total};

    // memory addressing, a new request reads the oldest waiter
    assign idx_plus = r_idx + CNT_W'(1);
    assign rd_off   = i_cmd.load ? '0 : (i_cmd.rd_next ? idx_plus : r_idx);
    assign rd_addr  = wrap_idx(SUM_W'(r_head) + SUM_W'(rd_off));
    assign wr_en    = i_cmd.enq || i_cmd.shift_wr;
    assign wr_addr  = i_cmd.shift_wr
                    ? wrap_idx(SUM_W'(r_head) + SUM_W'(r_idx) - SUM_W'(1))
                    : wrap_idx(SUM_W'(r_head) + SUM_W'(r_total));
    assign wr_data  = i_cmd.shift_wr ? r_rd_data : r_task_id;

    // status toward the controller
    assign o_stat.cnt_zero = (r_count == '0);
    assign o_stat.cnt_max  = &r_count;
    assign o_stat.q_empty  = (r_total == '0);
    assign o_stat.q_full   = (r_total == CNT_W'(MAX_WAITERS));
    assign o_stat.match    = (r_rd_data == r_task_id);
    assign o_stat.last     = (idx_plus == r_total);

    // next values of count, queue pointers and scan index
    always_comb begin
        n_count   = r_count;
        n_total   = r_total;
        n_head    = r_head;
        n_idx     = r_idx;
        n_task_id = r_task_id;
        n_woken   = r_woken;
        priority if (i_cfg_wr_en) begin
            n_count = cfg_ext[COUNT_BITS-1:0];
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - COUNT_BITS'(1);
        end else if (i_cmd.cnt_inc) begin
            n_count = r_count + COUNT_BITS'(1);
        end
        priority if (i_cmd.enq) begin
            n_total = r_total + CNT_W'(1);
        end else if (i_cmd.deq || i_cmd.drop) begin
            n_total = r_total - CNT_W'(1);
        end
        if (i_cmd.deq) begin
            n_head  = wrap_idx(SUM_W'(r_head) + SUM_W'(1));
            n_woken = r_rd_data;
        end
        priority if (i_cmd.load) begin
            n_idx     = '0;
            n_task_id = task_ext[TASK_ID_BITS-1:0];
            n_woken   = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = idx_plus;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_BITS'(1);
            r_total <= '0;
            r_head  <= '0;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            r_total <= n_total;
            r_head  <= n_head;
            r_idx   <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_task_id <= n_task_id;
        r_woken   <= n_woken;
        if (i_cmd.emit) begin
            r_out.status      <= i_cmd.status;
            r_out.woken_task  <= woken_ext[CSQ_TASK_W-1:0];
            r_out.count_now   <= count_ext[CSQ_COUNT_W-1:0];
            r_out.waiters_now <= total_ext[CSQ_WAITERS_W-1:0];
        end
    end

    // waiter ring, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_waiter_ids[wr_addr] <= wr_data;
        end
        r_rd_data <= r_waiter_ids[rd_addr];
    end

    assign o_out = r_out;

endmodule

// File: design/counting_semaphore_wait_queue.sv
// top level of the counting semaphore with a first-in first-out wait queue
//
//   channel  | signals                          | direction | transaction
//   ---------+----------------------------------+-----------+-------------------------
//   request  | i_in_valid, o_in_ready, i_in     | in        | op, task_id
//   result   | o_out_valid, i_out_ready, o_out  | out       | status, woken_task, counts
//   config   | i_cfg_wr_en, i_cfg_wr_data       | in        | initial_count, no wait
//
// acquire, try-acquire and release are accepted in S_IDLE, then executed in S_EXEC;
// cancel then has the single read port of the waiter ring walk the queue one entry
// a cycle until a match or the end, then on a match the same port closes the gap.
// reset loads a count of one; the ring is not cleared.
// a result waits in the output register while the next request is taken;
// a second result is held until the first one is delivered.
`timescale 1ns / 1ps

module counting_semaphore_wait_queue
    import csq_pkg::*;
#(
    parameter int MAX_WAITERS  = 16,
    parameter int TASK_ID_BITS = 8,
    parameter int COUNT_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CSQ_CFG_W-1:0] i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_csq_in              i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_csq_out             o_out
);

    t_csq_cmd  cmd;
    t_csq_stat stat;

    // sequencer
    csq_ctrl u_csq_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in.op),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // count, waiter ring and result register
    csq_dpath #(
        .MAX_WAITERS  (MAX_WAITERS),
        .TASK_ID_BITS (TASK_ID_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_csq_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_task_id     (i_in.task_id),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out         (o_out)
    );

endmodule

// File: design/csq_checker.sv
// port level checks for the counting semaphore wait queue
`timescale 1ns / 1ps

module csq_checker
    import csq_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input t_csq_in  i_in,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_csq_out o_out
);

    // one request at a time: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while previous one executes");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed or dropped while stalled");

    // woken task is only named by a release that wakes a waiter
    a_woken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != ST_WOKEN)) |-> (o_out.woken_task == '0))
        else $error("woken task set without a wake");

    // a task is queued only when no unit was left
    a_queued_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status == ST_QUEUED)) |-> (o_out.count_now == '0))
        else $error("task queued while units remain");

endmodule

bind counting_semaphore_wait_queue csq_checker u_csq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
